// File: rtl/pmat_pkg.sv
// Shared constants, trend codes and types for the per-channel moving average block.
`default_nettype none

package pmat_pkg;

   // Default sizes of the block.
   localparam int CHANNELS_DEF = 16;
   localparam int WINDOW_DEF   = 4;

   // Fixed field widths.
   localparam int CHAN_W  = 4;
   localparam int PRICE_W = 32;
   localparam int TREND_W = 2;

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // Trend codes.
   localparam logic [TREND_W-1:0] TREND_UP   = 2'd0;
   localparam logic [TREND_W-1:0] TREND_DOWN = 2'd1;
   localparam logic [TREND_W-1:0] TREND_SAME = 2'd2;

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// File: rtl/pmat_window.sv
// Price window memory for all channels, one write and one registered read port.
`default_nettype none

module pmat_window #(
   parameter int CHANNELS = pmat_pkg::CHANNELS_DEF,
   parameter int WINDOW   = pmat_pkg::WINDOW_DEF,
   localparam int DEPTH   = CHANNELS * WINDOW,
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [ADDR_W-1:0]            wr_addr,
   input  wire logic [pmat_pkg::PRICE_W-1:0] wr_data,
   input  wire logic                         rd_en,
   input  wire logic [ADDR_W-1:0]            rd_addr,
   output logic      [pmat_pkg::PRICE_W-1:0] rd_data
);

   logic [pmat_pkg::PRICE_W-1:0] mem [DEPTH];
   logic [pmat_pkg::PRICE_W-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/pmat_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module pmat_divider #(
   parameter int WINDOW  = pmat_pkg::WINDOW_DEF,
   localparam int CNT_W  = $clog2(WINDOW + 1),
   localparam int SUM_W  = pmat_pkg::PRICE_W + CNT_W,
   localparam int STEP_W = $clog2(SUM_W + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [SUM_W-1:0]             dividend,
   input  wire logic [CNT_W-1:0]             divisor,
   output logic      [pmat_pkg::PRICE_W-1:0] quotient,
   output pmat_pkg::div_status_type          status
);

   import pmat_pkg::*;

   logic [SUM_W-1:0]  work_ff, work_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;

   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   // One trial subtraction per step.
   assign trial = {rem_ff, work_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   // Quotient bits shift in at the bottom while the dividend shifts out at the top.
   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = STEP_W'(SUM_W);
      end else if (step_ff != '0) begin
         work_in = {work_ff[SUM_W-2:0], fits};
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         step_in = step_ff - STEP_W'(1);
         done_in = (step_ff == STEP_W'(1));
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign quotient    = work_ff[PRICE_W-1:0];
   assign status.busy = (step_ff != '0);
   assign status.done = done_ff;

endmodule

`default_nettype wire

// File: rtl/per_channel_moving_average_trend.sv
// Per-channel moving average with price and average trend codes, top level.
// An accepted beat passes through LOAD (ring update and window write), SUM (serial window
// sum), DIV (bit-serial divide) and FINISH before it reaches the response register.
// The block takes one item at a time: req_tready is high only while idle, so the serial
// window sum, the bit-serial divider and any response stall set the gap between beats.
// A channel outside CHANNELS goes straight to FINISH, skipping the window and divider.
// Reset is synchronous and clears all per-channel history; no clearing pass is needed.
`default_nettype none

module per_channel_moving_average_trend #(
   parameter int CHANNELS = pmat_pkg::CHANNELS_DEF,
   parameter int WINDOW   = pmat_pkg::WINDOW_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request: channel [3:0], price [35:4], zero [39:36].
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [pmat_pkg::REQ_DATA_W-1:0] req_tdata,
   // Response: channel_out [3:0], average [35:4], price_trend [37:36],
   // average_trend [39:38].
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [pmat_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import pmat_pkg::*;

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int MOD_W  = CNT_W + 1;
   localparam int SUM_W  = PRICE_W + CNT_W;
   localparam int DEPTH  = CHANNELS * WINDOW;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ST_W   = CNT_W + SLOT_W + 2 * PRICE_W;

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_SUM    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CHAN_W-1:0]   ch_ff, ch_in;
   logic [PRICE_W-1:0]  price_ff, price_in;
   logic                oor_ff, oor_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [SLOT_W-1:0]   oldest_ff, oldest_in;
   logic [PRICE_W-1:0]  last_price_ff, last_price_in;
   logic [PRICE_W-1:0]  last_avg_ff, last_avg_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [CHANNELS-1:0] chan_valid_ff;
   logic [ST_W-1:0]     st_rd_ff;
   logic [ST_W-1:0]     st_mem [CHANNELS];

   logic [8:0]          req_ch_wide, ch_wide;
   logic [CH_W-1:0]     req_idx, ch_idx;
   logic                req_take, req_in_range;
   logic                old_valid;
   logic [CNT_W-1:0]    cur_fill;
   logic [SLOT_W-1:0]   cur_oldest;
   logic [PRICE_W-1:0]  cur_last_price, cur_last_avg;
   logic [SLOT_W-1:0]   wr_slot, rd_slot;
   logic [CNT_W-1:0]    new_fill;
   logic [SLOT_W-1:0]   new_oldest;
   logic                win_wr_en, win_rd_en;
   logic [ADDR_W-1:0]   win_wr_addr, win_rd_addr;
   logic [PRICE_W-1:0]  win_rd_data;
   logic                div_start;
   logic [PRICE_W-1:0]  div_quotient;
   div_status_type      div_stat;
   logic                out_can, st_wr;
   logic [PRICE_W-1:0]  avg_val;
   logic [TREND_W-1:0]  price_trend, avg_trend;

   // Ring position modulo WINDOW for a value below twice WINDOW.
   function automatic logic [SLOT_W-1:0] wrap_slot(input logic [MOD_W-1:0] v);
      logic [MOD_W-1:0] r;
      r = (v >= MOD_W'(WINDOW)) ? (v - MOD_W'(WINDOW)) : v;
      return r[SLOT_W-1:0];
   endfunction

   // Window memory address of a channel's slot.
   function automatic logic [ADDR_W-1:0] addr_of(input logic [CH_W-1:0] ch,
                                                 input logic [SLOT_W-1:0] slot);
      logic [12:0] w;
      w = 13'(ch) * 13'(WINDOW) + 13'(slot);
      return w[ADDR_W-1:0];
   endfunction

   // Unsigned three-way compare.
   function automatic logic [TREND_W-1:0] trend_of(input logic [PRICE_W-1:0] now,
                                                   input logic [PRICE_W-1:0] prev);
      logic [TREND_W-1:0] t;
      if (now > prev) begin
         t = TREND_UP;
      end else if (now < prev) begin
         t = TREND_DOWN;
      end else begin
         t = TREND_SAME;
      end
      return t;
   endfunction

   // Channel indexes and range check.
   assign req_ch_wide  = {5'b0, req_tdata[CHAN_W-1:0]};
   assign req_idx      = req_ch_wide[CH_W-1:0];
   assign req_in_range = (req_ch_wide < 9'(CHANNELS));
   assign ch_wide      = {5'b0, ch_ff};
   assign ch_idx       = ch_wide[CH_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;

   // Per-channel state as read; a channel never written reads as all zero.
   assign old_valid      = chan_valid_ff[ch_idx];
   assign cur_fill       = old_valid ? st_rd_ff[ST_W-1 -: CNT_W] : '0;
   assign cur_oldest     = old_valid ? st_rd_ff[2*PRICE_W +: SLOT_W] : '0;
   assign cur_last_price = old_valid ? st_rd_ff[PRICE_W +: PRICE_W] : '0;
   assign cur_last_avg   = old_valid ? st_rd_ff[0 +: PRICE_W] : '0;

   // Ring update: append while filling, else overwrite the oldest slot.
   always_comb begin
      if (cur_fill < CNT_W'(WINDOW)) begin
         wr_slot    = wrap_slot(MOD_W'(cur_oldest) + MOD_W'(cur_fill));
         new_fill   = cur_fill + CNT_W'(1);
         new_oldest = cur_oldest;
      end else begin
         wr_slot    = cur_oldest;
         new_fill   = cur_fill;
         new_oldest = wrap_slot(MOD_W'(cur_oldest) + MOD_W'(1));
      end
   end

   // Window memory ports.
   assign win_wr_en   = (state_ff == S_LOAD);
   assign win_wr_addr = addr_of(ch_idx, wr_slot);
   assign rd_slot     = wrap_slot(MOD_W'(oldest_ff) + MOD_W'(idx_ff));
   assign win_rd_en   = (state_ff == S_SUM) && (idx_ff < fill_ff);
   assign win_rd_addr = addr_of(ch_idx, rd_slot);

   pmat_window #(
      .CHANNELS (CHANNELS),
      .WINDOW   (WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (win_wr_addr),
      .wr_data (price_ff),
      .rd_en   (win_rd_en),
      .rd_addr (win_rd_addr),
      .rd_data (win_rd_data)
   );

   // The divide starts once the last window read has been added in.
   assign div_start = (state_ff == S_SUM) && (idx_ff == fill_ff) && !pend_ff;

   pmat_divider #(
      .WINDOW (WINDOW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .quotient (div_quotient),
      .status   (div_stat)
   );

   // Result fields.
   assign out_can     = !rsp_valid_ff || rsp_tready;
   assign avg_val     = oor_ff ? '0 : div_quotient;
   assign price_trend = oor_ff ? TREND_SAME : trend_of(price_ff, last_price_ff);
   assign avg_trend   = oor_ff ? TREND_SAME : trend_of(avg_val, last_avg_ff);
   assign st_wr       = (state_ff == S_FINISH) && out_can && !oor_ff;

   // Sequencer and datapath next values.
   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      price_in      = price_ff;
      oor_in        = oor_ff;
      fill_in       = fill_ff;
      oldest_in     = oldest_ff;
      last_price_in = last_price_ff;
      last_avg_in   = last_avg_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      sum_in        = sum_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               ch_in    = req_tdata[CHAN_W-1:0];
               price_in = req_tdata[CHAN_W +: PRICE_W];
               oor_in   = !req_in_range;
               state_in = req_in_range ? S_LOAD : S_FINISH;
            end
         end
         S_LOAD: begin
            fill_in       = new_fill;
            oldest_in     = new_oldest;
            last_price_in = cur_last_price;
            last_avg_in   = cur_last_avg;
            idx_in        = '0;
            pend_in       = 1'b0;
            sum_in        = '0;
            state_in      = S_SUM;
         end
         S_SUM: begin
            if (win_rd_en) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            pend_in = win_rd_en;
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(win_rd_data);
            end
            if (div_start) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_can) begin
               rsp_data_in  = {avg_trend, price_trend, avg_val, ch_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         chan_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (st_wr) begin
            chan_valid_ff[ch_idx] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      price_ff      <= price_in;
      oor_ff        <= oor_in;
      fill_ff       <= fill_in;
      oldest_ff     <= oldest_in;
      last_price_ff <= last_price_in;
      last_avg_ff   <= last_avg_in;
      sum_ff        <= sum_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Per-channel state memory: read on acceptance, written back with the result.
   always_ff @(posedge clock) begin
      if (req_take) begin
         st_rd_ff <= st_mem[req_idx];
      end
      if (st_wr) begin
         st_mem[ch_idx] <= {fill_ff, oldest_ff, price_ff, avg_val};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_ready_drops: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted but block stayed ready");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DIV) && !div_stat.done) |-> div_stat.busy)
      else $error("sequencer waits on an idle divider");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |-> (idx_ff <= fill_ff))
      else $error("window read index ran past the fill count");

   a_result_out: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready))
      |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("finished item did not reach the response register");
`endif

endmodule

`default_nettype wire

// File: tb/sv/average_trend_check.sv
// Watches both stream channels, predicts each window average and trend pair, and compares.
`timescale 1ns / 1ps

module average_trend_check #(
   parameter int CHANNELS = pmat_pkg::CHANNELS_DEF,
   parameter int WINDOW   = pmat_pkg::WINDOW_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [pmat_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [pmat_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              errors,
   output int                              pending
);
   import pmat_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0]  channel;
      logic [PRICE_W-1:0] average;
      logic [TREND_W-1:0] price_trend;
      logic [TREND_W-1:0] average_trend;
   } average_beat_type;

   // Per-channel history as the block should hold it.
   logic [PRICE_W-1:0] ring_price [CHANNELS][WINDOW];
   int                 ring_fill  [CHANNELS];
   int                 ring_head  [CHANNELS];
   logic [PRICE_W-1:0] prev_price [CHANNELS];
   logic [PRICE_W-1:0] prev_avg   [CHANNELS];

   average_beat_type expected_averages[$];

   function automatic logic [TREND_W-1:0] trend_code(input logic [PRICE_W-1:0] now,
                                                     input logic [PRICE_W-1:0] prior);
      if (now > prior) return TREND_UP;
      if (now < prior) return TREND_DOWN;
      return TREND_SAME;
   endfunction

   // Updates the channel history with one price and returns the result it should give.
   function automatic average_beat_type predict_average(input logic [CHAN_W-1:0] ch,
                                                        input logic [PRICE_W-1:0] px);
      average_beat_type r;
      int            slot;
      int            n;
      logic [63:0]   sum;
      logic [PRICE_W-1:0] avg;
      r.channel = ch;
      // Channels beyond the configured count leave the history alone.
      if (int'(ch) >= CHANNELS) begin
         r.average       = '0;
         r.price_trend   = TREND_SAME;
         r.average_trend = TREND_SAME;
         return r;
      end
      // Append while filling, otherwise overwrite the oldest slot.
      if (ring_fill[ch] < WINDOW) begin
         slot = (ring_head[ch] + ring_fill[ch]) % WINDOW;
         ring_fill[ch]++;
      end else begin
         slot          = ring_head[ch];
         ring_head[ch] = (ring_head[ch] + 1) % WINDOW;
      end
      ring_price[ch][slot] = px;
      n   = ring_fill[ch];
      sum = '0;
      for (int i = 0; i < n; i++) begin
         sum += 64'(ring_price[ch][(ring_head[ch] + i) % WINDOW]);
      end
      avg             = PRICE_W'(sum / 64'(n));
      r.average       = avg;
      r.price_trend   = trend_code(px, prev_price[ch]);
      r.average_trend = trend_code(avg, prev_avg[ch]);
      prev_price[ch]  = px;
      prev_avg[ch]    = avg;
      return r;
   endfunction

   // Sample both channels at the rising edge; responses are matched before new requests.
   always @(posedge clock) begin
      average_beat_type want;
      average_beat_type got;
      average_beat_type fresh;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            ring_fill[c]  = 0;
            ring_head[c]  = 0;
            prev_price[c] = '0;
            prev_avg[c]   = '0;
         end
         expected_averages.delete();
         errors  <= 0;
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.channel       = rsp_tdata[3:0];
            got.average       = rsp_tdata[35:4];
            got.price_trend   = rsp_tdata[37:36];
            got.average_trend = rsp_tdata[39:38];
            if (expected_averages.size() == 0) begin
               if (errors < 10) begin
                  $display("%0t: response beat with nothing expected: ch %0d avg %h pt %0d at %0d",
                           $realtime, got.channel, got.average, got.price_trend,
                           got.average_trend);
               end
               errors <= errors + 1;
            end else begin
               want = expected_averages.pop_front();
               if (got.channel != want.channel || got.average != want.average ||
                   got.price_trend != want.price_trend ||
                   got.average_trend != want.average_trend) begin
                  if (errors < 10) begin
                     $display("%0t: mismatch expected ch %0d avg %h pt %0d at %0d", $realtime,
                              want.channel, want.average, want.price_trend,
                              want.average_trend);
                     $display("%0t:          actual   ch %0d avg %h pt %0d at %0d", $realtime,
                              got.channel, got.average, got.price_trend, got.average_trend);
                  end
                  errors <= errors + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            fresh = predict_average(req_tdata[3:0], req_tdata[35:4]);
            expected_averages.insert(expected_averages.size(), fresh);
         end
         pending <= expected_averages.size();
      end
   end

endmodule

// File: tb/sv/testbench.sv
// Top of the moving average testbench: clock, reset, price stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
   import pmat_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // channel [3:0], price [35:4], zero [39:36]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // channel_out, average, price_trend, average_trend
   int                    errors;
   int                    pending;

   // Largest idle gap either side may draw; zero gives stretches at full rate.
   int                    idle_cap;
   int                    rsp_beats;
   logic [PRICE_W-1:0]    last_sent [16];

   per_channel_moving_average_trend dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   average_trend_check trend_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .errors     (errors),
      .pending    (pending)
   );

   // Clock with a 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Generous bound on the whole run.
   initial begin
      #5000000;
      $display("testbench failed");
      $finish;
   end

   // Offer one price beat after a random gap and hold it until accepted.
   task automatic send_price(input logic [CHAN_W-1:0] ch, input logic [PRICE_W-1:0] px);
      int gap;
      gap = $urandom_range(0, idle_cap);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, px, ch};
      last_sent[ch] = px;
      do @(posedge clock); while (!req_tready);
   endtask

   // Random price that often repeats or sits at the ends of the range.
   function automatic logic [PRICE_W-1:0] pick_price(input logic [CHAN_W-1:0] ch);
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 3);
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
         2:       return last_sent[ch];
         3:       return last_sent[ch] + $urandom_range(0, 2) - 1;
         default: return $urandom;
      endcase
   endfunction

   // Response side: random stalls per beat, with two long hold-offs that back up the input.
   initial begin
      int hold;
      rsp_tready = 1'b0;
      rsp_beats  = 0;
      @(negedge reset);
      forever begin
         if (rsp_beats == 30 || rsp_beats == 330) begin
            hold = 400;
         end else begin
            hold = $urandom_range(0, idle_cap);
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_beats++;
      end
   end

   // Reset, directed cases, random phases, drain and verdict.
   initial begin
      logic [CHAN_W-1:0] ch;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      idle_cap   = 16;
      for (int c = 0; c < 16; c++) last_sent[c] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First samples at zero, growth to a full window of maximum prices, wrap and fall.
      send_price(4'd0, 32'h0000_0000);
      send_price(4'd0, 32'h0000_0000);
      send_price(4'd0, 32'h0000_0100);
      send_price(4'd0, 32'hFFFF_FFFF);
      send_price(4'd0, 32'hFFFF_FFFF);
      send_price(4'd0, 32'hFFFF_FFFF);
      send_price(4'd0, 32'hFFFF_FFFF);
      send_price(4'd0, 32'h0000_0000);
      send_price(4'd0, 32'h0000_0001);
      send_price(4'd0, 32'h0000_0001);
      // Highest channel, alternating bit patterns, first sample nonzero.
      send_price(4'd15, 32'hFFFF_FFFF);
      send_price(4'd15, 32'hAAAA_AAAA);
      send_price(4'd15, 32'h5555_5555);
      send_price(4'd15, 32'h8000_0000);
      send_price(4'd15, 32'h7FFF_FFFF);
      send_price(4'd15, 32'h7FFF_FFFF);
      // Steady price on a fresh channel gives equal trends once the window settles.
      send_price(4'd7, 32'h0000_0500);
      send_price(4'd7, 32'h0000_0500);
      send_price(4'd7, 32'h0000_0500);
      send_price(4'd9, 32'h0000_0000);

      // Random phases, alternating busy gaps and full-rate stretches.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0:       idle_cap = 16;
            1:       idle_cap = 0;
            default: idle_cap = 4;
         endcase
         for (int k = 0; k < 100; k++) begin
            // Mostly a few hot channels so windows fill and wrap often.
            ch = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
            send_price(ch, pick_price(ch));
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (60) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
